>>> design/sample_playback_position_top_assert.svh
// ----------------------------------------------------------------------------
// Sample playback position assertion macros
// Shared property forms for the port-level checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_PLAYBACK_POSITION_TOP_ASSERT_SVH
`define SAMPLE_PLAYBACK_POSITION_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPP_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPP_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spp assertion failed");

// Next-cycle implication that also holds through reset.
`define SPP_AST_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("spp assertion failed");

`endif

>>> design/spp_pkg.sv
// ----------------------------------------------------------------------------
// Sample playback position package
// Payload types, configuration layout and constants shared by the block.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MOD_STEPS  = 34;
  localparam int unsigned MOD_CNT_W  = $clog2(MOD_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_BASE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 3'd7;

  localparam logic [15:0] BLOCK_LENGTH_RST = 16'd64;
  localparam logic [33:0] TIME_MAX         = 34'h3_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] scene_pos;
    logic        play_enable;
    logic        gate_high;
  } in_data_t;

  typedef struct packed {
    logic        audible;
    logic [32:0] read_pos;
  } out_data_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] offset;
    logic [31:0] wrap_base;
    logic [31:0] wrap_len;
    logic [31:0] max_length;
    logic [31:0] start_pos;
    logic [31:0] file_length;
    logic [15:0] block_length;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    mode:         1'b0,
    offset:       32'd0,
    wrap_base:    32'd0,
    wrap_len:     32'd0,
    max_length:   32'd0,
    start_pos:    32'd0,
    file_length:  32'd0,
    block_length: BLOCK_LENGTH_RST
  };

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

>>> design/spp_stream_if.sv
// ----------------------------------------------------------------------------
// Sample playback position stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface spp_stream_if #(
  parameter type data_t = logic
) ();

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> design/spp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Sample playback position configuration registers
// Write-only register file; flags a file length write to clear play times.
// ----------------------------------------------------------------------------
module spp_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [spp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output spp_pkg::cfg_t                       cfg,
  output logic                                file_wr
);

  spp_pkg::cfg_t cfg_r;
  spp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        spp_pkg::CFG_MODE:         cfg_nxt.mode         = cfg_wdata[0];
        spp_pkg::CFG_OFFSET:       cfg_nxt.offset       = cfg_wdata;
        spp_pkg::CFG_WRAP_BASE:    cfg_nxt.wrap_base    = cfg_wdata;
        spp_pkg::CFG_WRAP_LEN:     cfg_nxt.wrap_len     = cfg_wdata;
        spp_pkg::CFG_MAX_LENGTH:   cfg_nxt.max_length   = cfg_wdata;
        spp_pkg::CFG_START_POS:    cfg_nxt.start_pos    = cfg_wdata;
        spp_pkg::CFG_FILE_LENGTH:  cfg_nxt.file_length  = cfg_wdata;
        spp_pkg::CFG_BLOCK_LENGTH: cfg_nxt.block_length = cfg_wdata[15:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= spp_pkg::CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg     = cfg_r;
  assign file_wr = cfg_we && (cfg_index == spp_pkg::CFG_FILE_LENGTH);

endmodule

>>> design/spp_mod_unit.sv
// ----------------------------------------------------------------------------
// Sample playback position modulo unit
// Restoring remainder of a 34-bit dividend by a 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module spp_mod_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [33:0]           dividend,
  input  logic [31:0]           divisor,
  output spp_pkg::mod_stat_t    stat,
  output logic [31:0]           rem
);

  logic                            busy_r;
  logic                            busy_nxt;
  logic                            done_r;
  logic                            done_nxt;
  logic [spp_pkg::MOD_CNT_W-1:0]   cnt_r;
  logic [spp_pkg::MOD_CNT_W-1:0]   cnt_nxt;
  logic [33:0]                     dvd_r;
  logic [33:0]                     dvd_nxt;
  logic [31:0]                     div_r;
  logic [31:0]                     div_nxt;
  logic [31:0]                     rem_r;
  logic [31:0]                     rem_nxt;
  logic [32:0]                     trial;
  logic [32:0]                     diff;

  assign trial = {rem_r, dvd_r[33]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, div_r}) ? diff[31:0] : trial[31:0];
      dvd_nxt = {dvd_r[32:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == spp_pkg::MOD_CNT_W'(spp_pkg::MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

>>> design/sample_playback_position_top.sv
// A silent or killed block gives its result from the evaluate state, an unlooped
// synced one through the sync-loop and window states, a looped one also through
// the modulo state. Free mode gives its result and then advances its play time,
// also running the modulo unit when the position wraps around the loop. A block
// is taken only once the last is done and its result has left. The 34-step
// remainder loop is the longest wait; synchronous reset clears control state.
// ----------------------------------------------------------------------------
// Sample playback position top level
// Sequencer that finds the read position and audibility of each audio block.
// ----------------------------------------------------------------------------
module sample_playback_position_top (
  input  logic                              clk,
  input  logic                              rst_n,
  spp_stream_if.sink                        in_chan,
  spp_stream_if.source                      out_chan,
  input  logic                              cfg_we,
  input  logic [spp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_SLOOP = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_WIN   = 3'd4;
  localparam logic [2:0] S_ADV   = 3'd5;
  localparam logic [2:0] S_FLOOP = 3'd6;

  spp_pkg::cfg_t       cfg;
  logic                file_wr;
  spp_pkg::mod_stat_t  mod_stat;
  logic [31:0]         mod_rem;
  logic                mod_start;
  logic [33:0]         mod_dvd;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  spp_pkg::out_data_t  out_data_r;
  spp_pkg::out_data_t  out_data_nxt;
  spp_pkg::in_data_t   item_r;
  spp_pkg::in_data_t   item_nxt;
  logic [34:0]         pos_r;
  logic [34:0]         pos_nxt;
  logic                free_phase_r;
  logic                free_phase_nxt;
  logic [33:0]         free_time_r;
  logic [33:0]         free_time_nxt;
  logic [33:0]         free_elapsed_r;
  logic [33:0]         free_elapsed_nxt;
  logic                gate_prev_r;
  logic                gate_prev_nxt;

  logic                looping;
  logic                gate_edge;
  logic [33:0]         time_eff;
  logic [33:0]         elapsed_eff;
  logic [32:0]         max_plus_blen;
  logic [31:0]         limit;
  logic [32:0]         limit_plus_blen;
  logic                in_window;
  logic [34:0]         time_sum;
  logic [34:0]         elapsed_sum;
  logic [32:0]         wrapped;

  spp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .file_wr   (file_wr)
  );

  spp_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (cfg.wrap_len),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  assign looping         = (cfg.wrap_len != '0);
  assign gate_edge       = item_r.gate_high && !gate_prev_r;
  assign time_eff        = gate_edge ? {2'b00, cfg.start_pos} : free_time_r;
  assign elapsed_eff     = gate_edge ? '0 : free_elapsed_r;
  assign max_plus_blen   = {1'b0, cfg.max_length} + {17'd0, cfg.block_length};
  assign limit           = (!cfg.mode && (cfg.max_length != '0) &&
                            (cfg.max_length < cfg.file_length)) ?
                           cfg.max_length : cfg.file_length;
  assign limit_plus_blen = {1'b0, limit} + {17'd0, cfg.block_length};
  assign in_window       = ($signed(pos_r) > $signed({19'd0, cfg.block_length})) &&
                           ($signed(pos_r) < $signed({2'b00, limit_plus_blen}));
  assign time_sum        = {1'b0, free_time_r} + {19'd0, cfg.block_length};
  assign elapsed_sum     = {1'b0, free_elapsed_r} + {19'd0, cfg.block_length};
  assign wrapped         = {1'b0, cfg.wrap_base} + {1'b0, mod_rem};

  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    item_nxt         = item_r;
    pos_nxt          = pos_r;
    free_phase_nxt   = free_phase_r;
    free_time_nxt    = free_time_r;
    free_elapsed_nxt = free_elapsed_r;
    gate_prev_nxt    = gate_prev_r;
    mod_start        = 1'b0;
    mod_dvd          = pos_r[33:0] - {2'b00, cfg.wrap_base};

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid && in_chan.ready) begin
          item_nxt  = in_chan.data;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if ((cfg.file_length == '0) || !item_r.play_enable) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
        end else if (!cfg.mode) begin
          pos_nxt   = {3'b000, item_r.scene_pos} + {{3{cfg.offset[31]}}, cfg.offset};
          state_nxt = S_SLOOP;
        end else begin
          free_time_nxt    = time_eff;
          free_elapsed_nxt = elapsed_eff;
          gate_prev_nxt    = item_r.gate_high;
          pos_nxt          = {1'b0, time_eff};
          if ((cfg.max_length != '0) && (elapsed_eff > {1'b0, max_plus_blen})) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_WIN;
          end
        end
      end
      S_SLOOP: begin
        if (looping && !pos_r[34] && (pos_r[33:0] >= {2'b00, cfg.wrap_base})) begin
          mod_start      = 1'b1;
          free_phase_nxt = 1'b0;
          state_nxt      = S_MOD;
        end else begin
          state_nxt = S_WIN;
        end
      end
      S_MOD: begin
        if (mod_stat.done) begin
          if (free_phase_r) begin
            free_time_nxt = {1'b0, wrapped};
            state_nxt     = S_IDLE;
          end else begin
            pos_nxt   = {2'b00, wrapped};
            state_nxt = S_WIN;
          end
        end
      end
      S_WIN: begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.audible  = in_window;
        out_data_nxt.read_pos = in_window ? pos_r[32:0] : '0;
        state_nxt             = cfg.mode ? S_ADV : S_IDLE;
      end
      S_ADV: begin
        free_time_nxt    = time_sum[34] ? spp_pkg::TIME_MAX : time_sum[33:0];
        free_elapsed_nxt = elapsed_sum[34] ? spp_pkg::TIME_MAX : elapsed_sum[33:0];
        state_nxt        = S_FLOOP;
      end
      S_FLOOP: begin
        mod_dvd = free_time_r - {2'b00, cfg.wrap_base};
        if (looping && (free_time_r >= {2'b00, cfg.wrap_base})) begin
          mod_start      = 1'b1;
          free_phase_nxt = 1'b1;
          state_nxt      = S_MOD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (file_wr) begin
      free_time_nxt    = '0;
      free_elapsed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      free_phase_r   <= 1'b0;
      free_time_r    <= '0;
      free_elapsed_r <= '0;
      gate_prev_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      free_phase_r   <= free_phase_nxt;
      free_time_r    <= free_time_nxt;
      free_elapsed_r <= free_elapsed_nxt;
      gate_prev_r    <= gate_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    item_r     <= item_nxt;
    pos_r      <= pos_nxt;
  end

  assign in_chan.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

>>> design/spp_checker.sv
// ----------------------------------------------------------------------------
// Sample playback position port checker
// Watches the top-level ports for sequencing and result consistency.
// ----------------------------------------------------------------------------
`include "sample_playback_position_top_assert.svh"

module spp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_audible,
  input logic [32:0] out_read_pos
);

  `SPP_AST_RST(a_reset_clears_out, !rst_n, !out_valid)
  `SPP_AST_NXT(a_busy_after_in, in_valid && in_ready, !in_ready)
  `SPP_AST_IMP(a_in_needs_free_out, in_valid && in_ready, !out_valid)
  `SPP_AST_IMP(a_silent_pos_zero, out_valid, out_audible == (out_read_pos != '0))
  `SPP_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_pos))

endmodule

bind sample_playback_position_top spp_checker u_spp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_audible  (out_chan.data.audible),
  .out_read_pos (out_chan.data.read_pos)
);
